/* hdl/bsrr_pkg.sv */
// Package for the random-removal id set: payload structs, op codes,
// memory request struct, controller states and a lowest-set-bit helper.
// No dependencies.
package bsrr_pkg;

  localparam int OP_W    = 2;
  localparam int ID_W    = 10;
  localparam int FRAC_W  = 16;
  localparam int COUNT_W = 11;
  localparam int WORD_W  = 32;
  localparam int BIT_AW  = 5;
  localparam int WADDR_W = ID_W - BIT_AW;
  localparam int ID_SPACE = 1 << ID_W;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   node_id;
    logic [FRAC_W-1:0] random_fraction;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]    picked_id;
    logic               found;
    logic [COUNT_W-1:0] member_count;
  } res_t;

  typedef struct packed {
    logic               rd_en;
    logic [WADDR_W-1:0] rd_addr;
    logic               wr_en;
    logic [WADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               clr;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ADD_WR,
    ST_RM_START,
    ST_RM_SCAN,
    ST_EMIT
  } state_t;

  function automatic logic [BIT_AW-1:0] lowest_bit(input logic [WORD_W-1:0] w);
    logic [BIT_AW-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = BIT_AW'(i);
      end
    end
    return idx;
  endfunction

endpackage

/* hdl/bsrr_mem.sv */
// Membership bitmap held as 32-bit words, with a registered synchronous read.
// Per-word valid flags clear all words together without writing them. Uses bsrr_pkg.
module bsrr_mem #(
  parameter int NUM_WORDS = 32,
  parameter int WORD_AW   = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bsrr_pkg::mem_req_t        req,
  output logic [bsrr_pkg::WORD_W-1:0] rdata
);
  import bsrr_pkg::*;

  logic [WORD_W-1:0]    mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] word_valid;
  logic [WORD_W-1:0]    rd_word;
  logic                 rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[WORD_AW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_word <= mem[req.rd_addr[WORD_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      word_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (req.wr_en) begin
        word_valid[req.wr_addr[WORD_AW-1:0]] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid <= word_valid[req.rd_addr[WORD_AW-1:0]];
      end
    end
  end

  assign rdata = rd_valid ? rd_word : '0;

endmodule

/* hdl/bsrr_ctrl.sv */
// Controller: decodes commands, read-modify-write of bitmap words, bounds,
// count, start-point multiply and word scan for removal. Uses bsrr_pkg.
module bsrr_ctrl #(
  parameter int MAX_IDS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  bsrr_pkg::cmd_t       cmd,
  output bsrr_pkg::mem_req_t   mem_req,
  input  logic [bsrr_pkg::WORD_W-1:0] mem_rdata,
  output bsrr_pkg::res_t       res,
  output logic                 res_pending,
  input  logic                 res_ready
);
  import bsrr_pkg::*;

  localparam int ID_LIMIT = (MAX_IDS < ID_SPACE) ? MAX_IDS : ID_SPACE;

  state_t state, state_next;

  cmd_t               cmd_r;
  logic [ID_W-1:0]    low;
  logic [ID_W-1:0]    high;
  logic [COUNT_W-1:0] count;
  logic [ID_W+FRAC_W-1:0] prod;
  logic [WADDR_W-1:0] start_w;
  logic [BIT_AW-1:0]  start_b;
  logic [WADDR_W-1:0] cur_w;
  logic               pass;
  logic [ID_W-1:0]    picked;
  logic               found;

  logic               accept;
  logic               in_range;
  logic [BIT_AW-1:0]  id_bit;
  logic [WORD_W-1:0]  id_mask;
  logic               add_hit;
  logic [ID_W-1:0]    span;
  logic [ID_W-1:0]    span_m1;
  logic [ID_W-1:0]    start_id;
  logic [WADDR_W-1:0] high_w;
  logic [WADDR_W-1:0] low_w;
  logic [WORD_W-1:0]  scan_mask;
  logic [WORD_W-1:0]  masked;
  logic               hit;
  logic [BIT_AW-1:0]  hit_bit;
  logic               scan_end;
  logic               scan_wrap;
  logic [WADDR_W-1:0] next_w;

  assign accept    = cmd_valid && !cmd_stall;
  assign in_range  = 32'(cmd_r.node_id) < ID_LIMIT;
  assign id_bit    = cmd_r.node_id[BIT_AW-1:0];
  assign id_mask   = WORD_W'(1) << id_bit;
  assign add_hit   = |(mem_rdata & id_mask);
  assign span      = high - low;
  assign span_m1   = span - ID_W'(1);
  assign start_id  = (span == '0) ? low : low + prod[ID_W+FRAC_W-1:FRAC_W];
  assign high_w    = high[ID_W-1:BIT_AW];
  assign low_w     = low[ID_W-1:BIT_AW];
  assign scan_mask = (!pass && cur_w == start_w) ? ({WORD_W{1'b1}} << start_b)
                                                 : {WORD_W{1'b1}};
  assign masked    = mem_rdata & scan_mask;
  assign hit       = |masked;
  assign hit_bit   = lowest_bit(masked);
  assign scan_end  = pass && cur_w == start_w;
  assign scan_wrap = !pass && cur_w == high_w;
  assign next_w    = scan_wrap ? low_w : WADDR_W'(cur_w + 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        case (cmd_r.op)
          OP_ADD:    state_next = in_range ? ST_ADD_WR : ST_EMIT;
          OP_REMOVE: state_next = (count != '0) ? ST_RM_START : ST_EMIT;
          default:   state_next = ST_EMIT;
        endcase
      end
      ST_ADD_WR:   state_next = ST_EMIT;
      ST_RM_START: state_next = ST_RM_SCAN;
      ST_RM_SCAN: begin
        if (hit || scan_end) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_req     = '0;
    cmd_stall   = 1'b1;
    res_pending = 1'b0;
    unique case (state)
      ST_IDLE: cmd_stall = 1'b0;
      ST_DECODE: begin
        if (cmd_r.op == OP_ADD && in_range) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = cmd_r.node_id[ID_W-1:BIT_AW];
        end
        mem_req.clr = (cmd_r.op == OP_CLEAR);
      end
      ST_ADD_WR: begin
        mem_req.wr_en   = !add_hit;
        mem_req.wr_addr = cmd_r.node_id[ID_W-1:BIT_AW];
        mem_req.wr_data = mem_rdata | id_mask;
      end
      ST_RM_START: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = start_id[ID_W-1:BIT_AW];
      end
      ST_RM_SCAN: begin
        if (hit) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = cur_w;
          mem_req.wr_data = mem_rdata & ~(WORD_W'(1) << hit_bit);
        end else if (!scan_end) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = next_w;
        end
      end
      ST_EMIT: res_pending = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low   <= '0;
      high  <= '0;
      count <= '0;
    end else begin
      case (state)
        ST_DECODE: begin
          if (cmd_r.op == OP_CLEAR) begin
            low   <= '0;
            high  <= '0;
            count <= '0;
          end
        end
        ST_ADD_WR: begin
          if (!add_hit) begin
            count <= count + 1'b1;
            if (count == '0) begin
              low  <= cmd_r.node_id;
              high <= cmd_r.node_id;
            end else if (cmd_r.node_id > high) begin
              high <= cmd_r.node_id;
            end else if (cmd_r.node_id < low) begin
              low <= cmd_r.node_id;
            end
          end
        end
        ST_RM_SCAN: begin
          if (hit) count <= count - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd_r  <= cmd;
          picked <= '0;
          found  <= 1'b0;
        end
      end
      ST_DECODE: begin
        prod <= (ID_W+FRAC_W)'(span_m1) * (ID_W+FRAC_W)'(cmd_r.random_fraction);
      end
      ST_RM_START: begin
        start_w <= start_id[ID_W-1:BIT_AW];
        start_b <= start_id[BIT_AW-1:0];
        cur_w   <= start_id[ID_W-1:BIT_AW];
        pass    <= 1'b0;
      end
      ST_RM_SCAN: begin
        if (hit) begin
          picked <= {cur_w, hit_bit};
          found  <= 1'b1;
        end else if (!scan_end) begin
          cur_w <= next_w;
          if (scan_wrap) pass <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign res.picked_id    = picked;
  assign res.found        = found;
  assign res.member_count = count;

`ifndef SYNTHESIS
  a_scan_finds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RM_SCAN) |-> (hit || !scan_end))
    else $error("removal scan ended without a member");

  a_bounds_order: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> (low <= high))
    else $error("lowest id above highest id");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(ID_LIMIT))
    else $error("member count above id limit");

  a_add_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD_WR && !add_hit) |=> (count == COUNT_W'($past(count) + 1'b1)))
    else $error("new member not counted");
`endif

endmodule

/* hdl/bitmap_set_random_remove.sv */
// Top level of the random-removal id set: controller, bitmap memory and
// result output register. Uses bsrr_pkg, bsrr_ctrl, bsrr_mem.
//
//   channel | direction | handshake            | payload
//   cmd     | in        | cmd_valid, cmd_stall | cmd (cmd_t)
//   res     | out       | res_valid, res_stall | res (res_t)
//
// One command at a time. Clear, unused op or remove on an empty set go from decode
// straight to the result; an in-range add reads its bitmap word and writes back a
// new member; remove scans the bitmap one word per cycle from the start word (the
// start word is read again after the wrap), as the bitmap memory has one read port.
// Reset empties the set through per-word valid flags.
// cmd_stall stays high from a transfer until its result enters the output
// register; a stalled result holds while the next command is processed.
module bitmap_set_random_remove #(
  parameter int MAX_IDS = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  bsrr_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_stall,
  output bsrr_pkg::res_t res
);
  import bsrr_pkg::*;

  localparam int ID_LIMIT  = (MAX_IDS < ID_SPACE) ? MAX_IDS : ID_SPACE;
  localparam int NUM_WORDS = (ID_LIMIT + WORD_W - 1) / WORD_W;
  localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  mem_req_t          mem_req;
  logic [WORD_W-1:0] mem_rdata;
  res_t              ctrl_res;
  logic              res_pending;
  logic              slot_free;
  logic              take;
  logic              res_valid_next;

  bsrr_mem #(
    .NUM_WORDS (NUM_WORDS),
    .WORD_AW   (WORD_AW)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  bsrr_ctrl #(
    .MAX_IDS (MAX_IDS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata),
    .res         (ctrl_res),
    .res_pending (res_pending),
    .res_ready   (slot_free)
  );

  assign slot_free      = !res_valid || !res_stall;
  assign take           = res_pending && slot_free;
  assign res_valid_next = take || (res_valid && res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= ctrl_res;
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Testbench for bitmap_set_random_remove: a directed table, then random add/remove/clear traffic,
// checked against fixed rows or an in-bench id-set predictor. Depends on bsrr_pkg and the RTL.
module testbench;
  import bsrr_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 650;
  localparam int QUIET_FROM   = 560;
  localparam int HOLD_AT      = 120;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_AT     = 330;
  localparam int STALL_LIMIT  = 3000;

  typedef struct {
    cmd_t c;
    bit   fixed;
    res_t r;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  bit idle_on = 1'b0;
  bit long_hold_req = 1'b0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  res_t expected_results[$];
  dir_row_t dir_rows[$];

  // predicted state of the id set
  bit [ID_SPACE-1:0] member_map;
  logic [ID_W-1:0] low_bound;
  logic [ID_W-1:0] high_bound;
  int member_total;

  bitmap_set_random_remove i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic res_t predict_set_op(input cmd_t c);
    res_t r;
    int span;
    int pos;
    longint start;
    r = '0;
    case (c.op)
      OP_ADD: begin
        if (!member_map[c.node_id]) begin
          if (member_total == 0) begin
            low_bound = c.node_id;
            high_bound = c.node_id;
          end else if (c.node_id > high_bound) begin
            high_bound = c.node_id;
          end else if (c.node_id < low_bound) begin
            low_bound = c.node_id;
          end
          member_map[c.node_id] = 1'b1;
          member_total++;
        end
      end
      OP_REMOVE: begin
        if (member_total != 0 && low_bound <= high_bound) begin
          span = int'(high_bound) - int'(low_bound);
          if (span == 0) begin
            start = low_bound;
          end else begin
            start = longint'(low_bound) + ((longint'(span - 1) * longint'(c.random_fraction)) >>> 16);
          end
          pos = int'(start);
          for (int i = 0; i <= span; i++) begin
            if (member_map[pos]) begin
              member_map[pos] = 1'b0;
              member_total--;
              r.picked_id = ID_W'(pos);
              r.found = 1'b1;
              break;
            end
            pos++;
            if (pos > int'(high_bound)) pos = low_bound;
          end
        end
      end
      OP_CLEAR: begin
        member_map = '0;
        low_bound = '0;
        high_bound = '0;
        member_total = 0;
      end
      default: begin
      end
    endcase
    r.member_count = COUNT_W'(member_total);
    return r;
  endfunction

  task automatic add_row(input logic [OP_W-1:0] op, input int id, input int frac,
                         input bit fixed, input int pid, input bit fnd, input int cnt);
    dir_row_t row;
    row.c.op = op;
    row.c.node_id = ID_W'(id);
    row.c.random_fraction = FRAC_W'(frac);
    row.fixed = fixed;
    row.r.picked_id = ID_W'(pid);
    row.r.found = fnd;
    row.r.member_count = COUNT_W'(cnt);
    dir_rows.push_back(row);
  endtask

  task automatic send_item(input cmd_t item, input bit has_fixed, input res_t fixed_res);
    res_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= item;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    predicted = predict_set_op(item);
    expected_results.push_back(has_fixed ? fixed_res : predicted);
  endtask

  initial begin
    cmd_t item;
    int n_sent;
    int seg_len;
    int id_mode;
    int add_pct;
    int win_width;
    int win_base;
    int pick;
    member_map = '0;
    low_bound = '0;
    high_bound = '0;
    member_total = 0;

    add_row(OP_REMOVE, 0, 16'h1234, 1, 0, 0, 0);
    add_row(OP_UNUSED, 0, 0, 1, 0, 0, 0);
    add_row(OP_ADD, 0, 0, 1, 0, 0, 1);
    add_row(OP_ADD, 0, 16'hFFFF, 1, 0, 0, 1);
    add_row(OP_REMOVE, 1023, 16'hFFFF, 1, 0, 1, 0);
    add_row(OP_ADD, 1023, 0, 1, 0, 0, 1);
    add_row(OP_REMOVE, 0, 0, 1, 1023, 1, 0);
    add_row(OP_ADD, 0, 0, 0, 0, 0, 0);
    add_row(OP_ADD, 1023, 0, 0, 0, 0, 0);
    add_row(OP_ADD, 512, 0, 0, 0, 0, 0);
    add_row(OP_REMOVE, 0, 16'hFFFF, 0, 0, 0, 0);
    add_row(OP_REMOVE, 0, 0, 0, 0, 0, 0);
    add_row(OP_CLEAR, 1023, 16'hFFFF, 1, 0, 0, 0);
    add_row(OP_REMOVE, 0, 16'h8000, 1, 0, 0, 0);
    add_row(OP_ADD, 5, 0, 0, 0, 0, 0);
    add_row(OP_ADD, 3, 0, 0, 0, 0, 0);
    add_row(OP_ADD, 9, 0, 0, 0, 0, 0);
    add_row(OP_ADD, 3, 16'h5555, 0, 0, 0, 0);
    add_row(OP_REMOVE, 0, 16'hFFFF, 0, 0, 0, 0);
    add_row(OP_REMOVE, 0, 16'hFFFF, 0, 0, 0, 0);
    add_row(OP_REMOVE, 0, 16'h1234, 0, 0, 0, 0);
    add_row(OP_REMOVE, 0, 16'h8000, 0, 0, 0, 0);
    add_row(OP_UNUSED, 1023, 16'hFFFF, 0, 0, 0, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].c, dir_rows[i].fixed, dir_rows[i].r);

    n_sent = 0;
    while (n_sent < RANDOM_ITEMS) begin
      seg_len = $urandom_range(10, 50);
      id_mode = $urandom_range(0, 2);
      add_pct = $urandom_range(30, 75);
      win_width = $urandom_range(0, 40);
      win_base = $urandom_range(0, 1023 - win_width);
      idle_on = (n_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      for (int k = 0; k < seg_len && n_sent < RANDOM_ITEMS; k++) begin
        if (n_sent >= QUIET_FROM) idle_on = 1'b0;
        if (n_sent == HOLD_AT) long_hold_req = 1'b1;
        if (n_sent == DRAIN_AT) begin
          cmd_valid <= 1'b0;
          @(posedge clk);
          while (expected_results.size() != 0) @(posedge clk);
        end
        item.node_id = ID_W'($urandom_range(0, 1023));
        item.random_fraction = FRAC_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          item.op = OP_UNUSED;
        end else if (pick < 5) begin
          item.op = OP_CLEAR;
        end else if (pick < 5 + add_pct) begin
          item.op = OP_ADD;
          case (id_mode)
            1: item.node_id = ID_W'(win_base + $urandom_range(0, win_width));
            2: item.node_id = ID_W'($urandom_range(0, 1) ? $urandom_range(0, 15)
                                                          : $urandom_range(1008, 1023));
            default: begin
            end
          endcase
        end else begin
          item.op = OP_REMOVE;
          case ($urandom_range(0, 9))
            0: item.random_fraction = '0;
            1: item.random_fraction = '1;
            default: begin
            end
          endcase
        end
        send_item(item, 1'b0, '0);
        n_sent++;
      end
    end

    cmd_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  // result check on every output transfer
  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: picked=%0d found=%0d count=%0d",
                   res.picked_id, res.found, res.member_count);
      end else begin
        want = expected_results.pop_front();
        if (res.picked_id !== want.picked_id || res.found !== want.found ||
            res.member_count !== want.member_count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp picked=%0d found=%0d count=%0d, got picked=%0d found=%0d count=%0d",
                     want.picked_id, want.found, want.member_count,
                     res.picked_id, res.found, res.member_count);
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule
